[rtl/chained_address_hash_table_macros.svh]
// ----------------------------------------------------------------------------
// chained address hash table assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CHAINED_ADDRESS_HASH_TABLE_MACROS_SVH
`define CHAINED_ADDRESS_HASH_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CAHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define CAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/caht_pkg.sv]
// ----------------------------------------------------------------------------
// caht_pkg
// shared types and codes of the chained address hash table
// ----------------------------------------------------------------------------
`default_nettype none

package caht_pkg;

  localparam logic [2:0] OP_LOOKUP     = 3'd0;
  localparam logic [2:0] OP_SET        = 3'd1;
  localparam logic [2:0] OP_SET_ABSENT = 3'd2;
  localparam logic [2:0] OP_UPDATE     = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NEW    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BKT, S_HREAD, S_HTAKE, S_WALK, S_CMP,
    S_ACT, S_CHK, S_GCLR, S_GBKT, S_GHD, S_GENT, S_GRD, S_GNH
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic clr_new;
    logic load_in;
    logic do_hash;
    logic do_bucket;
    logic rd_head;
    logic take_head;
    logic rd_entry;
    logic step;
    logic act;
    logic g_rd_old;
    logic g_take;
    logic g_rd_new;
    logic g_link;
    logic g_next;
    logic g_finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic e_nil;
    logic key_hit;
    logic grow;
    logic gi_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/caht_ctrl.sv]
// ----------------------------------------------------------------------------
// caht_ctrl
// sequencer for request handling, chain walk, clearing and rehash
// ----------------------------------------------------------------------------
`default_nettype none

module caht_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire caht_pkg::sts_t  sts,
  output caht_pkg::cmd_t       cmd
);

  caht_pkg::state_t state_r, state_nxt;
  logic done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= caht_pkg::S_CLEAR;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // done_r marks a result waiting for the output register
  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    unique case (state_r)
      caht_pkg::S_CLEAR: if (sts.clr_last) state_nxt = caht_pkg::S_IDLE;
      caht_pkg::S_IDLE: begin
        if (done_r) begin
          if (sts.out_free) done_nxt = 1'b0;
        end else if (in_valid) begin
          state_nxt = caht_pkg::S_HASH;
        end
      end
      caht_pkg::S_HASH:  state_nxt = caht_pkg::S_BKT;
      caht_pkg::S_BKT:   state_nxt = caht_pkg::S_HREAD;
      caht_pkg::S_HREAD: state_nxt = caht_pkg::S_HTAKE;
      caht_pkg::S_HTAKE: state_nxt = caht_pkg::S_WALK;
      caht_pkg::S_WALK:  state_nxt = sts.e_nil ? caht_pkg::S_ACT : caht_pkg::S_CMP;
      caht_pkg::S_CMP:   state_nxt = sts.key_hit ? caht_pkg::S_ACT : caht_pkg::S_WALK;
      caht_pkg::S_ACT:   state_nxt = caht_pkg::S_CHK;
      caht_pkg::S_CHK: begin
        done_nxt  = 1'b1;
        state_nxt = sts.grow ? caht_pkg::S_GCLR : caht_pkg::S_IDLE;
      end
      caht_pkg::S_GCLR: if (sts.clr_last) state_nxt = caht_pkg::S_GBKT;
      caht_pkg::S_GBKT: state_nxt = caht_pkg::S_GHD;
      caht_pkg::S_GHD:  state_nxt = caht_pkg::S_GENT;
      caht_pkg::S_GENT: begin
        if (!sts.e_nil)       state_nxt = caht_pkg::S_GRD;
        else if (sts.gi_last) state_nxt = caht_pkg::S_IDLE;
        else                  state_nxt = caht_pkg::S_GBKT;
      end
      caht_pkg::S_GRD: state_nxt = caht_pkg::S_GNH;
      caht_pkg::S_GNH: state_nxt = caht_pkg::S_GENT;
      default:         state_nxt = caht_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      caht_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
      caht_pkg::S_IDLE: begin
        in_ready     = !done_r;
        cmd.load_in  = !done_r && in_valid;
        cmd.load_out = done_r && sts.out_free;
      end
      caht_pkg::S_HASH:  cmd.do_hash   = 1'b1;
      caht_pkg::S_BKT:   cmd.do_bucket = 1'b1;
      caht_pkg::S_HREAD: cmd.rd_head   = 1'b1;
      caht_pkg::S_HTAKE: cmd.take_head = 1'b1;
      caht_pkg::S_WALK:  cmd.rd_entry  = !sts.e_nil;
      caht_pkg::S_CMP:   cmd.step      = !sts.key_hit;
      caht_pkg::S_ACT:   cmd.act       = 1'b1;
      caht_pkg::S_CHK:   cmd           = '0;
      caht_pkg::S_GCLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.clr_new = 1'b1;
      end
      caht_pkg::S_GBKT: cmd.g_rd_old = 1'b1;
      caht_pkg::S_GHD:  cmd.g_take   = 1'b1;
      caht_pkg::S_GENT: begin
        cmd.rd_entry = !sts.e_nil;
        cmd.g_next   = sts.e_nil;
        cmd.g_finish = sts.e_nil && sts.gi_last;
      end
      caht_pkg::S_GRD: cmd.g_rd_new = 1'b1;
      caht_pkg::S_GNH: cmd.g_link   = 1'b1;
      default:         cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/caht_dp.sv]
// ----------------------------------------------------------------------------
// caht_dp
// hash, bucket heads, entry pool memories, free list and result register
// ----------------------------------------------------------------------------
`default_nettype none

module caht_dp #(
  parameter int POOL_ENTRIES    = 256,
  parameter int MAX_BUCKET_BITS = 8,
  parameter int START_BUCKETS   = 4,
  parameter int CHAIN_LIMIT     = 3,
  parameter int GROW_BITS       = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire caht_pkg::cmd_t  cmd,
  output caht_pkg::sts_t       sts,
  input  wire logic [2:0]      in_operation,
  input  wire logic [63:0]     in_key,
  input  wire logic [63:0]     in_value,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [63:0]          out_result_value
);

  localparam int IW  = $clog2(POOL_ENTRIES);
  localparam int LW  = $clog2(POOL_ENTRIES + 1);
  localparam int BW  = MAX_BUCKET_BITS;
  localparam int BBW = $clog2(MAX_BUCKET_BITS + 1);
  localparam int SB  = $clog2(START_BUCKETS);
  localparam int B0  = (SB > MAX_BUCKET_BITS) ? MAX_BUCKET_BITS : SB;
  localparam int HD  = 2 << BW;
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  function automatic logic [BW-1:0] bucket_of(input logic [31:0] h,
                                              input logic [BBW-1:0] nb);
    logic [32:0] sum;
    logic [32:0] mask;
    sum  = {1'b0, h} + ({1'b0, h} >> (6'd32 - 6'(nb)));
    mask = (33'd1 << nb) - 33'd1;
    return BW'(sum & mask);
  endfunction

  // memories
  logic [LW-1:0] heads_mem [HD];
  logic [63:0]   keys_mem  [POOL_ENTRIES];
  logic [63:0]   vals_mem  [POOL_ENTRIES];
  logic [LW-1:0] links_mem [POOL_ENTRIES];
  logic [31:0]   hash_mem  [POOL_ENTRIES];
  logic [IW-1:0] rec_mem   [POOL_ENTRIES];

  logic [LW-1:0] heads_q, link_q;
  logic [63:0]   key_q, val_q;
  logic [31:0]   hash_q;
  logic [IW-1:0] rec_q;

  // control state
  logic [BBW-1:0] bits_r, gnb_r;
  logic           bank_r, grow_r;
  logic [LW-1:0]  fresh_r, rc_r;
  logic [BW:0]    clr_r, gi_r;

  // payload state
  logic [2:0]    op_r;
  logic [63:0]   key_r, val_r;
  logic [31:0]   h_r;
  logic [BW-1:0] bkt_r, gb_r;
  logic [LW-1:0] e_r, prev_r, head_r, nxt_r;
  logic [1:0]    st_r;
  logic [63:0]   res_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [63:0]   out_value_r;

  logic [LW-1:0]  live;
  logic           full, hit, ins, dele;
  logic [IW-1:0]  new_idx;
  logic [BBW:0]   gsum;
  logic [BBW-1:0] gnb_calc, clr_bits;
  logic [31:0]    prod, thr, live_new;
  logic [1:0]     st_nxt;
  logic [63:0]    res_nxt;

  logic          hd_we, hd_re;
  logic [BW:0]   hd_wa, hd_ra;
  logic [LW-1:0] hd_wd;
  logic          ln_we;
  logic [IW-1:0] ln_wa;
  logic [LW-1:0] ln_wd;
  logic          vl_we;
  logic [IW-1:0] vl_wa;

  assign live     = fresh_r - rc_r;
  assign full     = (fresh_r == NIL) && (rc_r == '0);
  assign hit      = (e_r != NIL);
  assign new_idx  = (rc_r != '0) ? rec_q : fresh_r[IW-1:0];
  assign gsum     = {1'b0, bits_r} + (BBW + 1)'(GROW_BITS);
  assign gnb_calc = (gsum > (BBW + 1)'(MAX_BUCKET_BITS)) ? BBW'(MAX_BUCKET_BITS)
                                                         : gsum[BBW-1:0];
  assign clr_bits = cmd.clr_new ? gnb_r : bits_r;
  assign prod     = key_r[34:3] * caht_pkg::HASH_MULT;
  assign thr      = 32'(CHAIN_LIMIT) << bits_r;
  assign live_new = 32'(live) + 32'd1;

  assign sts.clr_last = (clr_r + (BW + 1)'(1)) == ((BW + 1)'(1) << clr_bits);
  assign sts.e_nil    = (e_r == NIL);
  assign sts.key_hit  = (key_q == key_r);
  assign sts.grow     = grow_r;
  assign sts.gi_last  = (gi_r + (BW + 1)'(1)) == ((BW + 1)'(1) << bits_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // operation decode and memory write selection
  always_comb begin
    st_nxt  = caht_pkg::ST_ABSENT;
    res_nxt = '0;
    ins     = 1'b0;
    dele    = 1'b0;
    vl_we   = 1'b0;
    vl_wa   = e_r[IW-1:0];
    case (op_r)
      caht_pkg::OP_LOOKUP: begin
        st_nxt  = hit ? caht_pkg::ST_FOUND : caht_pkg::ST_ABSENT;
        res_nxt = hit ? val_q : val_r;
      end
      caht_pkg::OP_SET, caht_pkg::OP_SET_ABSENT: begin
        if (hit) begin
          st_nxt = caht_pkg::ST_FOUND;
          if (op_r == caht_pkg::OP_SET_ABSENT && val_q != '0) begin
            res_nxt = val_q;
          end else begin
            vl_we   = 1'b1;
            res_nxt = val_r;
          end
        end else if (full) begin
          st_nxt = caht_pkg::ST_FULL;
        end else begin
          st_nxt  = caht_pkg::ST_NEW;
          ins     = 1'b1;
          vl_we   = 1'b1;
          vl_wa   = new_idx;
          res_nxt = val_r;
        end
      end
      caht_pkg::OP_UPDATE: begin
        if (hit) begin
          st_nxt  = caht_pkg::ST_FOUND;
          vl_we   = 1'b1;
          res_nxt = val_r;
        end
      end
      caht_pkg::OP_DELETE: begin
        if (hit) begin
          st_nxt  = caht_pkg::ST_FOUND;
          dele    = 1'b1;
          res_nxt = val_q;
        end
      end
      default: begin
        st_nxt  = caht_pkg::ST_ABSENT;
        res_nxt = '0;
      end
    endcase
    ins   = ins && cmd.act;
    dele  = dele && cmd.act;
    vl_we = vl_we && cmd.act;

    hd_we = 1'b0;
    hd_wa = {bank_r, bkt_r};
    hd_wd = NIL;
    ln_we = 1'b0;
    ln_wa = prev_r[IW-1:0];
    ln_wd = link_q;
    if (cmd.clr_wr) begin
      hd_we = 1'b1;
      hd_wa = {cmd.clr_new ? !bank_r : bank_r, clr_r[BW-1:0]};
    end else if (cmd.g_link) begin
      hd_we = 1'b1;
      hd_wa = {!bank_r, gb_r};
      hd_wd = e_r;
      ln_we = 1'b1;
      ln_wa = e_r[IW-1:0];
      ln_wd = heads_q;
    end else if (ins) begin
      hd_we = 1'b1;
      hd_wd = LW'(new_idx);
      ln_we = 1'b1;
      ln_wa = new_idx;
      ln_wd = head_r;
    end else if (dele) begin
      // unlink from the bucket head or from the previous entry
      hd_we = (prev_r == NIL);
      hd_wd = link_q;
      ln_we = (prev_r != NIL);
    end

    hd_re = cmd.rd_head || cmd.g_rd_old || cmd.g_rd_new;
    hd_ra = {bank_r, bkt_r};
    if (cmd.g_rd_old) hd_ra = {bank_r, gi_r[BW-1:0]};
    if (cmd.g_rd_new) hd_ra = {!bank_r, bucket_of(hash_q, gnb_r)};
  end

  always_ff @(posedge clk) begin
    if (hd_we) heads_mem[hd_wa] <= hd_wd;
    if (hd_re) heads_q <= heads_mem[hd_ra];
  end

  always_ff @(posedge clk) begin
    if (ln_we) links_mem[ln_wa] <= ln_wd;
    if (vl_we) vals_mem[vl_wa] <= val_r;
    if (ins) begin
      keys_mem[new_idx] <= key_r;
      hash_mem[new_idx] <= h_r;
    end
    if (dele) rec_mem[rc_r[IW-1:0]] <= e_r[IW-1:0];
    if (cmd.rd_entry) begin
      key_q  <= keys_mem[e_r[IW-1:0]];
      val_q  <= vals_mem[e_r[IW-1:0]];
      link_q <= links_mem[e_r[IW-1:0]];
      hash_q <= hash_mem[e_r[IW-1:0]];
    end
    if (cmd.rd_head) rec_q <= rec_mem[IW'(rc_r - LW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= BBW'(B0);
      bank_r      <= 1'b0;
      fresh_r     <= '0;
      rc_r        <= '0;
      clr_r       <= '0;
      gi_r        <= '0;
      grow_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_r <= sts.clr_last ? '0 : clr_r + (BW + 1)'(1);
      if (ins) begin
        if (rc_r != '0) rc_r <= rc_r - LW'(1);
        else            fresh_r <= fresh_r + LW'(1);
      end
      if (dele) rc_r <= rc_r + LW'(1);
      if (cmd.act) begin
        grow_r <= ins && (live_new > thr) && (bits_r < BBW'(MAX_BUCKET_BITS));
        gnb_r  <= gnb_calc;
      end
      if (cmd.g_finish) begin
        gi_r   <= '0;
        bank_r <= !bank_r;
        bits_r <= gnb_r;
      end else if (cmd.g_next) begin
        gi_r <= gi_r + (BW + 1)'(1);
      end
      if (cmd.load_out)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.do_hash)   h_r   <= prod;
    if (cmd.do_bucket) bkt_r <= bucket_of(h_r, bits_r);
    if (cmd.take_head) begin
      e_r    <= heads_q;
      head_r <= heads_q;
      prev_r <= NIL;
    end
    if (cmd.step) begin
      prev_r <= e_r;
      e_r    <= link_q;
    end
    if (cmd.g_take) e_r <= heads_q;
    if (cmd.g_rd_new) begin
      gb_r  <= bucket_of(hash_q, gnb_r);
      nxt_r <= link_q;
    end
    if (cmd.g_link) e_r <= nxt_r;
    if (cmd.act) begin
      st_r  <= st_nxt;
      res_r <= res_nxt;
    end
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_value_r  <= res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

endmodule

`default_nettype wire

[rtl/chained_address_hash_table.sv]
// one request at a time; the next transfer is taken only once the previous result
//   has been loaded into the output register
// a growing insert clears the new bucket heads, then relinks every entry of each old bucket
// reset: synchronous, active low; afterwards the live bucket heads are cleared,
//   one per cycle, before the first transfer
`default_nettype none

// ----------------------------------------------------------------------------
// chained_address_hash_table
// word-keyed hash table with separate chaining over a fixed entry pool
// ----------------------------------------------------------------------------
module chained_address_hash_table #(
  parameter int POOL_ENTRIES    = 256,
  parameter int MAX_BUCKET_BITS = 8,
  parameter int START_BUCKETS   = 4,
  parameter int CHAIN_LIMIT     = 3,
  parameter int GROW_BITS       = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [63:0] in_key,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [63:0]      out_result_value
);

  // command and status between sequencer and datapath
  caht_pkg::cmd_t cmd;
  caht_pkg::sts_t sts;

  // sequencer: request flow, chain walk, head clearing and rehash walk
  caht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: hash multiplier, bucket heads (two banks for rehash),
  // entry pool, free list and the output register
  caht_dp #(
    .POOL_ENTRIES    (POOL_ENTRIES),
    .MAX_BUCKET_BITS (MAX_BUCKET_BITS),
    .START_BUCKETS   (START_BUCKETS),
    .CHAIN_LIMIT     (CHAIN_LIMIT),
    .GROW_BITS       (GROW_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .in_value         (in_value),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

endmodule

`default_nettype wire

[rtl/caht_chk.sv]
// ----------------------------------------------------------------------------
// caht_chk
// port-level checks of the chained address hash table
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_address_hash_table_macros.svh"

module caht_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_operation,
  input wire logic [63:0] in_key,
  input wire logic [63:0] in_value,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [63:0] out_result_value
);

  logic         out_wait, in_wait, in_take;
  logic [130:0] in_payload;
  logic [65:0]  out_payload;

  assign out_wait    = out_valid && !out_ready;
  assign in_wait     = in_valid && !in_ready;
  assign in_take     = in_valid && in_ready;
  assign in_payload  = {in_operation, in_key, in_value};
  assign out_payload = {out_status, out_result_value};

  `CAHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid)
  `CAHT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_wait, $stable(out_payload))
  `CAHT_ASSERT_NEXT(a_in_stable, clk, rst_n, in_wait, in_valid && $stable(in_payload))
  `CAHT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_take, !in_ready)
  `CAHT_ASSERT_NOW(a_full_zero, clk, rst_n, out_valid && out_status == caht_pkg::ST_FULL, out_result_value == 64'd0)

endmodule

bind chained_address_hash_table caht_chk u_chk (.*);

`default_nettype wire
